// File: hw/rtl/psnc_pkg.sv
// Shared constants for the palette store with nearest color search.
// Field widths, command codes and default palette size; no dependencies.
package psnc_pkg;

    localparam int PALETTE_ENTRIES = 256;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 16;
    localparam int CH_W    = 8;
    localparam int DIST_W  = 18;
    localparam int SQ_W    = 2 * CH_W;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

endpackage

// File: hw/rtl/palette_store_nearest_color_top.sv
// Palette store with write, lookup and nearest RGB color search.
// Depends on psnc_pkg for widths, command codes and defaults.
//
// Usage:
//   Slave channel s_*: one command per transfer. s_tuser carries the command
//   (0 write, 1 lookup, 2 nearest search, 3 no operation); s_tdata carries
//   index, color, red, green and blue.
//   Master channel m_*: exactly one result transfer per command, in order,
//   with color_out, best_index and best_distance packed in m_tdata.
//   Write and no operation go straight to the emit state; a lookup reads
//   the memory first; a search scans the palette and drains the pipeline.
//   The block takes one command at a time: s_tready is high only while
//   no command is in progress. A search walks the palette through one
//   memory read port and one distance unit, one entry per cycle, and
//   occupies the block until the last entry has been compared.
//   A finished result sits in the output register until taken; the next
//   command is accepted meanwhile and its result waits until the output
//   register frees up.
//   Reset clears every palette entry to zero at once (per-entry valid flags)
//   and empties the output register; no clearing pass is needed.
module palette_store_nearest_color_top #(
    parameter int PALETTE_ENTRIES = psnc_pkg::PALETTE_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] index, [23:8] color, [31:24] red, [39:32] green, [47:40] blue
    input  logic [psnc_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [psnc_pkg::CMD_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] color_out, [23:16] best_index, [41:24] best_distance,
    // [47:42] zero
    output logic [psnc_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int IDX_W   = psnc_pkg::IDX_W;
    localparam int COLOR_W = psnc_pkg::COLOR_W;
    localparam int CH_W    = psnc_pkg::CH_W;
    localparam int DIST_W  = psnc_pkg::DIST_W;
    localparam int SQ_W    = psnc_pkg::SQ_W;
    localparam int AW      = $clog2(PALETTE_ENTRIES);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(PALETTE_ENTRIES - 1);
    localparam logic [IDX_W:0] ENTRIES_X = (IDX_W + 1)'(PALETTE_ENTRIES);
    localparam int PAD_W = psnc_pkg::M_DATA_W - COLOR_W - IDX_W - DIST_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SEARCH,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // input fields
    logic [IDX_W-1:0]   in_index;
    logic [COLOR_W-1:0] in_color;
    logic [CH_W-1:0]    in_red;
    logic [CH_W-1:0]    in_green;
    logic [CH_W-1:0]    in_blue;
    psnc_pkg::cmd_t     in_cmd;
    logic               s_fire;
    logic               in_range;

    assign in_index = s_tdata[7:0];
    assign in_color = s_tdata[23:8];
    assign in_red   = s_tdata[31:24];
    assign in_green = s_tdata[39:32];
    assign in_blue  = s_tdata[47:40];
    assign in_cmd   = psnc_pkg::cmd_t'(s_tuser);
    assign in_range = ({1'b0, in_index} < ENTRIES_X);

    state_t              state_reg;
    logic [AW-1:0]       scan_reg;
    logic                lk_range_reg;
    logic                m_tvalid_reg;
    logic [COLOR_W-1:0]  out_color_reg;
    logic [IDX_W-1:0]    out_index_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic [COLOR_W-1:0]  res_color_reg;
    logic [IDX_W-1:0]    res_index_reg;
    logic [DIST_W-1:0]   res_dist_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // move the pending result into the output register
    logic                out_load;

    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    // palette memory with per-entry valid flags cleared by reset
    logic [COLOR_W-1:0]  mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] ent_valid_reg;
    logic                mem_we;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [COLOR_W-1:0]  rd_data_reg;
    logic                rd_valid_reg;
    logic [COLOR_W-1:0]  rd_entry;

    assign mem_we  = s_fire && (in_cmd == psnc_pkg::CMD_WRITE) && in_range;
    assign wr_addr = in_index[AW-1:0];
    assign rd_addr = (state_reg == ST_IDLE) ? in_index[AW-1:0] : scan_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= in_color;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                ent_valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= ent_valid_reg[rd_addr];
        end
    end

    // an entry never written reads as zero
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

    // search pipeline: read, square, sum and compare
    logic                rd_vld_reg;
    logic                rd_last_reg;
    logic [AW-1:0]       rd_idx_reg;
    logic                sq_vld_reg;
    logic                sq_last_reg;
    logic [AW-1:0]       sq_idx_reg;
    logic [COLOR_W-1:0]  sq_color_reg;
    logic [SQ_W-1:0]     sq_r_reg;
    logic [SQ_W-1:0]     sq_g_reg;
    logic [SQ_W-1:0]     sq_b_reg;
    logic [CH_W-1:0]     tgt_r_reg;
    logic [CH_W-1:0]     tgt_g_reg;
    logic [CH_W-1:0]     tgt_b_reg;
    logic [DIST_W-1:0]   best_dist_reg;
    logic [AW-1:0]       best_idx_reg;
    logic [COLOR_W-1:0]  best_color_reg;

    logic [CH_W-1:0]     exp_r;
    logic [CH_W-1:0]     exp_g;
    logic [CH_W-1:0]     exp_b;
    logic [CH_W-1:0]     dif_r;
    logic [CH_W-1:0]     dif_g;
    logic [CH_W-1:0]     dif_b;
    logic [DIST_W-1:0]   cand_dist;
    logic                take;
    logic [DIST_W-1:0]   win_dist;
    logic [AW-1:0]       win_idx;
    logic [COLOR_W-1:0]  win_color;

    always_comb
    begin
        exp_r = {rd_entry[15:11], 3'b000};
        exp_g = {rd_entry[10:5], 2'b00};
        exp_b = {rd_entry[4:0], 3'b000};
        dif_r = (tgt_r_reg >= exp_r) ? (tgt_r_reg - exp_r) : (exp_r - tgt_r_reg);
        dif_g = (tgt_g_reg >= exp_g) ? (tgt_g_reg - exp_g) : (exp_g - tgt_g_reg);
        dif_b = (tgt_b_reg >= exp_b) ? (tgt_b_reg - exp_b) : (exp_b - tgt_b_reg);
    end

    always_comb
    begin
        cand_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
        // first entry seeds the minimum; strict less keeps the lowest index
        take      = (sq_idx_reg == '0) || (cand_dist < best_dist_reg);
        win_dist  = take ? cand_dist : best_dist_reg;
        win_idx   = take ? sq_idx_reg : best_idx_reg;
        win_color = take ? sq_color_reg : best_color_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            tgt_r_reg <= in_red;
            tgt_g_reg <= in_green;
            tgt_b_reg <= in_blue;
        end
        rd_idx_reg   <= scan_reg;
        sq_idx_reg   <= rd_idx_reg;
        sq_color_reg <= rd_entry;
        sq_r_reg     <= dif_r * dif_r;
        sq_g_reg     <= dif_g * dif_g;
        sq_b_reg     <= dif_b * dif_b;
        if (sq_vld_reg)
        begin
            best_dist_reg  <= win_dist;
            best_idx_reg   <= win_idx;
            best_color_reg <= win_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            sq_vld_reg  <= 1'b0;
            sq_last_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= (state_reg == ST_SEARCH);
            rd_last_reg <= (state_reg == ST_SEARCH) && (scan_reg == LAST_ADDR);
            sq_vld_reg  <= rd_vld_reg;
            sq_last_reg <= rd_last_reg;
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            lk_range_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            out_color_reg <= '0;
            out_index_reg <= '0;
            out_dist_reg  <= '0;
            res_color_reg <= '0;
            res_index_reg <= '0;
            res_dist_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        res_color_reg <= '0;
                        res_index_reg <= '0;
                        res_dist_reg  <= '0;
                        lk_range_reg  <= in_range;
                        scan_reg      <= '0;
                        case (in_cmd)
                            psnc_pkg::CMD_WRITE:
                            begin
                                res_color_reg <= in_color;
                                state_reg     <= ST_EMIT;
                            end
                            psnc_pkg::CMD_LOOKUP:
                            begin
                                state_reg <= ST_LOOKUP;
                            end
                            psnc_pkg::CMD_SEARCH:
                            begin
                                state_reg <= ST_SEARCH;
                            end
                            default:
                            begin
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_LOOKUP:
                begin
                    res_color_reg <= lk_range_reg ? rd_entry : '0;
                    state_reg     <= ST_EMIT;
                end
                ST_SEARCH:
                begin
                    // advance one entry per cycle
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (sq_vld_reg && sq_last_reg)
                    begin
                        res_color_reg <= win_color;
                        res_index_reg <= IDX_W'(win_idx);
                        res_dist_reg  <= win_dist;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    // hold the result until the output register frees up
                    if (out_load)
                    begin
                        out_color_reg <= res_color_reg;
                        out_index_reg <= res_index_reg;
                        out_dist_reg  <= res_dist_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_dist_reg, out_index_reg, out_color_reg};

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && scan_reg == LAST_ADDR) |=> state_reg == ST_DRAIN)
        else $error("search scan did not end after the last entry");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_vld_reg && sq_last_reg) |=> state_reg == ST_EMIT)
        else $error("last compared entry did not produce a result");

    a_pipe_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld_reg |-> (state_reg == ST_SEARCH || state_reg == ST_DRAIN))
        else $error("distance pipeline active outside a search");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && (!m_tvalid_reg || m_tready))
        |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("result not moved into the output register");

endmodule

// File: sim/tb_top.sv
// Testbench for palette_store_nearest_color_top: directed and random commands.
// Depends on psnc_pkg and the top level; results are checked against a shadow palette.
`timescale 1ns / 100ps

module tb_top;

    localparam int PALETTE_ENTRIES = psnc_pkg::PALETTE_ENTRIES;
    localparam int CMD_W           = psnc_pkg::CMD_W;
    localparam int IDX_W           = psnc_pkg::IDX_W;
    localparam int COLOR_W         = psnc_pkg::COLOR_W;
    localparam int CH_W            = psnc_pkg::CH_W;
    localparam int DIST_W          = psnc_pkg::DIST_W;
    localparam int S_DATA_W        = psnc_pkg::S_DATA_W;
    localparam int M_DATA_W        = psnc_pkg::M_DATA_W;

    localparam int RANDOM_ITEMS  = 1700;
    localparam int DRAIN_EVERY   = 600;
    localparam int SETTLE_CYCLES = PALETTE_ENTRIES + 40;

    typedef struct packed {
        logic [COLOR_W-1:0] color_out;
        logic [IDX_W-1:0]   best_index;
        logic [DIST_W-1:0]  best_distance;
    } result_t;

    typedef struct packed {
        psnc_pkg::cmd_t     cmd;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic               typed;
        result_t            res;
    } row_t;

    typedef enum logic [1:0] {
        RX_READY,
        RX_RANDOM,
        RX_CHOKED
    } rx_mode_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    logic [COLOR_W-1:0]   palette_shadow [PALETTE_ENTRIES];
    result_t              pending_results [$];
    row_t                 directed_rows [$];
    int                   error_count = 0;

    rx_mode_t             rx_mode = RX_READY;
    int                   rx_mode_left = 0;

    palette_store_nearest_color_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [DIST_W-1:0] color_distance(
        input logic [COLOR_W-1:0] c,
        input logic [CH_W-1:0]    red,
        input logic [CH_W-1:0]    green,
        input logic [CH_W-1:0]    blue
    );
        int dr;
        int dg;
        int db;
        dr = int'(red)   - int'({c[15:11], 3'b000});
        dg = int'(green) - int'({c[10:5], 2'b00});
        db = int'(blue)  - int'({c[4:0], 3'b000});
        return DIST_W'(dr * dr + dg * dg + db * db);
    endfunction

    // Advance the shadow palette by one command and return its result.
    function automatic result_t apply_command(input row_t r);
        result_t          res;
        logic [DIST_W-1:0] d;
        res = '0;
        case (r.cmd)
            psnc_pkg::CMD_WRITE:
            begin
                if (int'(r.idx) < PALETTE_ENTRIES)
                    palette_shadow[r.idx] = r.color;
                res.color_out = r.color;
            end
            psnc_pkg::CMD_LOOKUP:
            begin
                if (int'(r.idx) < PALETTE_ENTRIES)
                    res.color_out = palette_shadow[r.idx];
            end
            psnc_pkg::CMD_SEARCH:
            begin
                res.best_distance = color_distance(palette_shadow[0], r.red, r.green, r.blue);
                for (int i = 1; i < PALETTE_ENTRIES; i++)
                begin
                    d = color_distance(palette_shadow[i], r.red, r.green, r.blue);
                    // strict compare: the lowest index keeps a tie
                    if (d < res.best_distance)
                    begin
                        res.best_index    = IDX_W'(i);
                        res.best_distance = d;
                    end
                end
                res.color_out = palette_shadow[res.best_index];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [CH_W-1:0] clamp_channel(input int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return 8'hFF;
        return CH_W'(v);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // Hold the command on the bus until a transfer happens; valid stays high.
    task automatic send_command(input row_t r);
        result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {r.blue, r.green, r.red, r.color, r.idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = apply_command(r);
        pending_results.push_back(r.typed ? r.res : predicted);
    endtask

    function automatic row_t random_command();
        row_t r;
        int   pick;
        int   k;
        r.idx   = IDX_W'($urandom);
        r.color = COLOR_W'($urandom);
        r.red   = CH_W'($urandom);
        r.green = CH_W'($urandom);
        r.blue  = CH_W'($urandom);
        r.typed = 1'b0;
        r.res   = '0;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            r.cmd = psnc_pkg::CMD_WRITE;
            // copy an existing color now and then to build ties
            case ($urandom_range(0, 7))
                0, 1: r.color = palette_shadow[$urandom_range(0, PALETTE_ENTRIES - 1)];
                2:    r.color = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                default: ;
            endcase
        end
        else if (pick < 65)
            r.cmd = psnc_pkg::CMD_LOOKUP;
        else if (pick < 95)
        begin
            r.cmd = psnc_pkg::CMD_SEARCH;
            if ($urandom_range(0, 1) == 0)
            begin
                k = $urandom_range(0, PALETTE_ENTRIES - 1);
                r.red   = clamp_channel(int'({palette_shadow[k][15:11], 3'b000})
                                        + int'($urandom_range(0, 8)) - 4);
                r.green = clamp_channel(int'({palette_shadow[k][10:5], 2'b00})
                                        + int'($urandom_range(0, 8)) - 4);
                r.blue  = clamp_channel(int'({palette_shadow[k][4:0], 3'b000})
                                        + int'($urandom_range(0, 8)) - 4);
            end
        end
        else
            r.cmd = psnc_pkg::CMD_NONE;
        return r;
    endfunction

    // Receiver: switch between always ready, coin flip and mostly stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            rx_mode      <= RX_READY;
            rx_mode_left <= 0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       rx_mode <= RX_READY;
                    1:       rx_mode <= RX_RANDOM;
                    default: rx_mode <= RX_CHOKED;
                endcase
                rx_mode_left <= $urandom_range(20, 400);
            end
            else
                rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                RX_READY:  m_tready <= 1'b1;
                RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                default:   m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result transfer", m_tdata, 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.color_out)
                    report_mismatch("color_out", m_tdata[15:0], want.color_out);
                if (m_tdata[23:16] !== want.best_index)
                    report_mismatch("best_index", m_tdata[23:16], want.best_index);
                if (m_tdata[41:24] !== want.best_distance)
                    report_mismatch("best_distance", m_tdata[41:24], want.best_distance);
                if (m_tdata[47:42] !== '0)
                    report_mismatch("tdata pad", m_tdata[47:42], 0);
            end
        end
    end

    initial
    begin : stimulus
        int   sent;
        int   burst;
        int   gap;
        int   next_drain;
        bit   drain;
        row_t r;

        foreach (palette_shadow[i])
            palette_shadow[i] = '0;

        // cmd, index, color, red, green, blue, typed, {color_out, best_index, best_distance}
        directed_rows.push_back('{psnc_pkg::CMD_LOOKUP, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'h0000, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_LOOKUP, 8'd255, 16'hFFFF, 8'd255, 8'd255, 8'd255,
                                  1'b1, '{16'h0000, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_SEARCH, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'h0000, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_SEARCH, 8'd0,   16'h0000, 8'd255, 8'd255, 8'd255,
                                  1'b1, '{16'h0000, 8'd0, 18'd195075}});
        directed_rows.push_back('{psnc_pkg::CMD_NONE,   8'd255, 16'hFFFF, 8'd255, 8'd255, 8'd255,
                                  1'b1, '{16'h0000, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_WRITE,  8'd0,   16'hFFFF, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'hFFFF, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_WRITE,  8'd255, 16'hFFFF, 8'd255, 8'd255, 8'd255,
                                  1'b1, '{16'hFFFF, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_LOOKUP, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'hFFFF, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_LOOKUP, 8'd255, 16'h0000, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'hFFFF, 8'd0, 18'd0}});
        // entries 0 and 255 tie at white: lowest index wins
        directed_rows.push_back('{psnc_pkg::CMD_SEARCH, 8'd0,   16'h0000, 8'd255, 8'd255, 8'd255,
                                  1'b1, '{16'hFFFF, 8'd0, 18'd107}});
        directed_rows.push_back('{psnc_pkg::CMD_SEARCH, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'h0000, 8'd1, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_WRITE,  8'd128, 16'hF800, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'hF800, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_SEARCH, 8'd0,   16'h0000, 8'd255, 8'd0,   8'd0,
                                  1'b0, '0});
        directed_rows.push_back('{psnc_pkg::CMD_WRITE,  8'd1,   16'h07E0, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'h07E0, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_SEARCH, 8'd0,   16'h0000, 8'd0,   8'd255, 8'd0,
                                  1'b0, '0});
        directed_rows.push_back('{psnc_pkg::CMD_WRITE,  8'd2,   16'h001F, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'h001F, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_SEARCH, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd255,
                                  1'b0, '0});
        directed_rows.push_back('{psnc_pkg::CMD_SEARCH, 8'd77,  16'h1234, 8'd128, 8'd64,  8'd200,
                                  1'b0, '0});
        directed_rows.push_back('{psnc_pkg::CMD_NONE,   8'd0,   16'h0000, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'h0000, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_WRITE,  8'd3,   16'h0000, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'h0000, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_LOOKUP, 8'd128, 16'h0000, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'hF800, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_LOOKUP, 8'd3,   16'hFFFF, 8'd0,   8'd0,   8'd0,
                                  1'b1, '{16'h0000, 8'd0, 18'd0}});
        directed_rows.push_back('{psnc_pkg::CMD_SEARCH, 8'd0,   16'h0000, 8'd248, 8'd252, 8'd248,
                                  1'b1, '{16'hFFFF, 8'd0, 18'd0}});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_command(directed_rows[i]);

        sent       = 0;
        next_drain = DRAIN_EVERY;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                r = random_command();
                send_command(r);
                sent++;
            end
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            drain = (sent >= next_drain);
            if (drain && gap == 0)
                gap = 1;
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= S_DATA_W'({$urandom, $urandom});
                s_tuser  <= CMD_W'($urandom);
                repeat (gap) @(posedge clk);
                if (drain)
                begin
                    // hold off until the block has handed back everything
                    while (pending_results.size() != 0)
                        @(posedge clk);
                    next_drain += DRAIN_EVERY;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
